### src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted minimum priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int VALUE_W          = 32;
  localparam int OCC_W            = 8;
  localparam int CAPACITY_DEFAULT = 128;

  // action codes
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic                      action;
    logic signed [VALUE_W-1:0] value;
  } spq_cmd_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] removed_value;
    logic [1:0]                status;
    logic [OCC_W-1:0]          occupancy;
  } spq_rsp_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_ctl_t;

endpackage

### src/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds one entry, shifts up on insert, down on
// removal.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 8
) (
  input  logic                               clk,
  input  spq_pkg::spq_ctl_t                  ctl,
  input  logic [CW-1:0]                      count,
  input  logic signed [spq_pkg::VALUE_W-1:0] value,
  input  logic signed [spq_pkg::VALUE_W-1:0] prev_entry,
  input  logic                               prev_ins,
  input  logic signed [spq_pkg::VALUE_W-1:0] next_entry,
  output logic signed [spq_pkg::VALUE_W-1:0] entry,
  output logic                               ins
);

  localparam logic [CW-1:0] IDX = CW'(INDEX);

  // Mark slots at or behind the insert point: live and greater, or first free
  assign ins = ((IDX < count) && (value < entry)) || (IDX == count);

  // Take the new value at the insert point, the neighbor's entry behind it; on dequeue take the next entry
  always_ff @(posedge clk) begin
    if (ctl.enq && ins) begin
      entry <= prev_ins ? prev_entry : value;
    end else if (ctl.deq) begin
      entry <= next_entry;
    end
  end

endmodule

### src/sorted_min_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_min_priority_queue
// Ascending priority queue kept as a sorted chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) carries an action and a value.
//   An enqueue places the value behind every stored value less than or equal
//   to it; a dequeue removes the smallest entry and returns it.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns one item per command:
//   removed value, status (ok, overflow, underflow) and the new occupancy.
// Timing:
//   Every cell compares the incoming value with its own entry and hands its
//   entry to a neighbor in the same cycle, and the response sits in the
//   output register the cycle after the command is accepted. One command is
//   accepted per cycle while the response is taken or none waits.
// Stall:
//   cmd_stall is high while a response waits and rsp_stall is high; the
//   response holds until taken.
// Reset:
//   rst empties the queue (count to zero) and drops any pending response.
//   Entry storage is not cleared; slots at or above the count are unused.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  spq_pkg::spq_cmd_t cmd,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output spq_pkg::spq_rsp_t rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_CNT = CW'(1);

  logic [CW-1:0]                      count;
  logic [CW-1:0]                      count_next;
  logic                               cmd_accept;
  logic                               full;
  logic                               empty;
  spq_pkg::spq_ctl_t                  ctl;
  logic [1:0]                         status_next;
  logic signed [spq_pkg::VALUE_W-1:0] removed_next;

  logic signed [spq_pkg::VALUE_W-1:0] entry [CAPACITY];
  logic                               ins   [CAPACITY];

  // Accept a command whenever the output register is free or being drained
  assign cmd_stall  = rsp_valid && rsp_stall;
  assign cmd_accept = cmd_valid && !cmd_stall;

  assign full  = (count == CAP_CNT);
  assign empty = (count == '0);

  // Decode the command into chain control and a status code
  always_comb begin
    ctl          = '0;
    status_next  = spq_pkg::ST_OK;
    removed_next = '0;
    count_next   = count;
    if (cmd.action == spq_pkg::ACT_ENQ) begin
      if (full) begin
        status_next = spq_pkg::ST_OVERFLOW;
      end else begin
        ctl.enq    = cmd_accept;
        count_next = count + ONE_CNT;
      end
    end else begin
      if (empty) begin
        status_next = spq_pkg::ST_UNDERFLOW;
      end else begin
        ctl.deq      = cmd_accept;
        removed_next = entry[0];
        count_next   = count - ONE_CNT;
      end
    end
  end

  // Build the chain; the head sees no insert ahead of it, the tail keeps itself
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [spq_pkg::VALUE_W-1:0] prev_entry;
    logic                               prev_ins;
    logic signed [spq_pkg::VALUE_W-1:0] next_entry;

    if (i == 0) begin : g_head
      assign prev_entry = cmd.value;
      assign prev_ins   = 1'b0;
    end else begin : g_body
      assign prev_entry = entry[i-1];
      assign prev_ins   = ins[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_entry = entry[i];
    end else begin : g_mid
      assign next_entry = entry[i+1];
    end

    spq_cell #(
      .INDEX (i),
      .CW    (CW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count),
      .value      (cmd.value),
      .prev_entry (prev_entry),
      .prev_ins   (prev_ins),
      .next_entry (next_entry),
      .entry      (entry[i]),
      .ins        (ins[i])
    );
  end

  // Advance the count on accepted commands
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd_accept) begin
      count <= count_next;
    end
  end

  // Hold the response until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd_accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      rsp.removed_value <= removed_next;
      rsp.status        <= status_next;
      rsp.occupancy     <= spq_pkg::OCC_W'(count_next);
    end
  end

endmodule

### src/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the sorted minimum priority queue.
// ----------------------------------------------------------------------------
module spq_checker #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
  input logic              clk,
  input logic              rst,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input spq_pkg::spq_rsp_t rsp
);

  localparam logic [spq_pkg::OCC_W-1:0] CAP_OCC = spq_pkg::OCC_W'(CAPACITY);

  // Drop any pending response at reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // Report only the defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == spq_pkg::ST_OK || rsp.status == spq_pkg::ST_OVERFLOW ||
                   rsp.status == spq_pkg::ST_UNDERFLOW))
    else $error("undefined status code");

  // Return zero on every failed command
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != spq_pkg::ST_OK) |-> (rsp.removed_value == '0))
    else $error("nonzero value on failed command");

  // Tie failure codes to an empty or full queue
  a_fail_occ: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((rsp.status != spq_pkg::ST_UNDERFLOW || rsp.occupancy == '0) &&
                   (rsp.status != spq_pkg::ST_OVERFLOW || rsp.occupancy == CAP_OCC)))
    else $error("failure status does not match occupancy");

  // Hold a stalled response
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled response changed");

endmodule

bind sorted_min_priority_queue spq_checker #(
  .CAPACITY (CAPACITY)
) u_spq_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
